FILE: src/cbp_pkg.sv
package cbp_pkg;

    localparam int DEFAULT_MAX_COUNTER_WIDTH = 32;
    localparam int BITS_PER_BYTE             = 8;
    localparam int PARTIAL_W                 = 7;
    localparam int PCOUNT_W                  = 3;
    localparam int CFG_W                     = 6;
    localparam int IN_W                      = 32;
    localparam int APB_DATA_W                = 32;
    localparam int APB_ADDR_W                = 2;

    localparam logic [CFG_W-1:0]      COUNTER_WIDTH_RESET = 6'd4;
    localparam logic [APB_ADDR_W-1:0] ADDR_COUNTER_WIDTH  = 2'd0;

    typedef struct packed {
        logic in_full;
        logic [PCOUNT_W-1:0] partial_count;
    } pack_status_t;

endpackage

FILE: src/cbp_cfg.sv
module cbp_cfg
    import cbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CFG_W-1:0]      counter_width
);

    logic [CFG_W-1:0] counter_width_reg;
    logic             wr_en;

    assign pready        = 1'b1;
    assign wr_en         = psel && penable && pwrite && (paddr == ADDR_COUNTER_WIDTH);
    assign counter_width = counter_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_width_reg <= COUNTER_WIDTH_RESET;
        end
        else if (wr_en)
        begin
            counter_width_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_COUNTER_WIDTH)
        begin
            prdata = APB_DATA_W'(counter_width_reg);
        end
    end

endmodule

FILE: src/cbp_pack.sv
module cbp_pack
    import cbp_pkg::*;
#(
    parameter int MAX_COUNTER_WIDTH = DEFAULT_MAX_COUNTER_WIDTH,
    localparam int WORD_W = MAX_COUNTER_WIDTH + PARTIAL_W,
    localparam int BYTES  = (WORD_W + BITS_PER_BYTE - 1) / BITS_PER_BYTE,
    localparam int NB_W   = $clog2(BYTES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CFG_W-1:0]   counter_width,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [IN_W-1:0]    count_word,
    input  logic               last_counter,
    input  logic               emit_free,
    output logic               load,
    output logic [WORD_W-1:0]  load_word,
    output logic [NB_W-1:0]    load_count,
    output logic               load_last,
    output pack_status_t       status
);

    localparam int WID_W = $clog2(MAX_COUNTER_WIDTH + 1);
    localparam int TOT_W = $clog2(WORD_W + 1);

    logic                   in_full_reg;
    logic                   in_full_next;
    logic [IN_W-1:0]        value_reg;
    logic                   last_reg;
    logic [PARTIAL_W-1:0]   partial_bits_reg;
    logic [PARTIAL_W-1:0]   partial_bits_next;
    logic [PCOUNT_W-1:0]    partial_count_reg;
    logic [PCOUNT_W-1:0]    partial_count_next;

    logic                              accept;
    logic [WID_W-1:0]                  w_eff;
    logic [MAX_COUNTER_WIDTH+IN_W-1:0] value_ext;
    logic [MAX_COUNTER_WIDTH-1:0]      masked;
    logic [TOT_W-1:0]                  total;
    logic [WORD_W-1:0]                 shifted;

    assign accept       = in_valid && !in_stall;
    assign in_stall     = in_full_reg && !emit_free;
    assign load         = in_full_reg && emit_free;
    assign in_full_next = accept ? 1'b1 : (load ? 1'b0 : in_full_reg);

    always_comb
    begin
        if (counter_width == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (int'(counter_width) > MAX_COUNTER_WIDTH)
        begin
            w_eff = WID_W'(MAX_COUNTER_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(counter_width);
        end
    end

    assign value_ext = {{MAX_COUNTER_WIDTH{1'b0}}, value_reg};

    always_comb
    begin
        for (int i = 0; i < MAX_COUNTER_WIDTH; i++)
        begin
            masked[i] = value_ext[i] && (i < int'(w_eff));
        end
    end

    assign load_word  = (WORD_W'(masked) << partial_count_reg) | WORD_W'(partial_bits_reg);
    assign total      = TOT_W'(partial_count_reg) + TOT_W'(w_eff);
    assign load_count = NB_W'(total >> 3) + NB_W'(last_reg && (total[2:0] != 3'd0));
    assign load_last  = last_reg;
    assign shifted    = load_word >> (total & ~TOT_W'(7));

    always_comb
    begin
        partial_bits_next  = partial_bits_reg;
        partial_count_next = partial_count_reg;
        if (load)
        begin
            if (last_reg)
            begin
                partial_bits_next  = '0;
                partial_count_next = '0;
            end
            else
            begin
                partial_bits_next  = shifted[PARTIAL_W-1:0];
                partial_count_next = total[PCOUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg       <= 1'b0;
            partial_bits_reg  <= '0;
            partial_count_reg <= '0;
        end
        else
        begin
            in_full_reg       <= in_full_next;
            partial_bits_reg  <= partial_bits_next;
            partial_count_reg <= partial_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= count_word;
            last_reg  <= last_counter;
        end
    end

    assign status.in_full       = in_full_reg;
    assign status.partial_count = partial_count_reg;

endmodule

FILE: src/cbp_emit.sv
module cbp_emit
    import cbp_pkg::*;
#(
    parameter int MAX_COUNTER_WIDTH = DEFAULT_MAX_COUNTER_WIDTH,
    localparam int WORD_W = MAX_COUNTER_WIDTH + PARTIAL_W,
    localparam int BYTES  = (WORD_W + BITS_PER_BYTE - 1) / BITS_PER_BYTE,
    localparam int NB_W   = $clog2(BYTES + 1),
    localparam int EMIT_W = BYTES * BITS_PER_BYTE
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [WORD_W-1:0]        load_word,
    input  logic [NB_W-1:0]          load_count,
    input  logic                     load_last,
    output logic                     emit_free,
    output logic [NB_W-1:0]          pending,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [BITS_PER_BYTE-1:0] out_byte,
    output logic                     last_byte
);

    logic [EMIT_W-1:0] word_reg;
    logic [NB_W-1:0]   count_reg;
    logic              last_reg;
    logic              xfer;

    assign out_valid = (count_reg != '0);
    assign xfer      = out_valid && !out_stall;
    assign emit_free = (count_reg == '0) || ((count_reg == NB_W'(1)) && xfer);
    assign out_byte  = word_reg[BITS_PER_BYTE-1:0];
    assign last_byte = last_reg && (count_reg == NB_W'(1));
    assign pending   = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            last_reg  <= 1'b0;
        end
        else if (load)
        begin
            count_reg <= load_count;
            last_reg  <= load_last;
        end
        else if (xfer)
        begin
            count_reg <= count_reg - NB_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= EMIT_W'(load_word);
        end
        else if (xfer)
        begin
            word_reg <= word_reg >> BITS_PER_BYTE;
        end
    end

endmodule

FILE: src/counter_bit_packer.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    count_word, last_counter
// out      output     out_valid / out_stall  out_byte, last_byte
// cfg      input      APB, pready always 1   counter_width at address 0
//
// A counter is registered on transfer, packed once the emitter is free and handed to the
// byte emitter, which sends one byte per cycle from its output register unless stalled.
// A counter yields between zero and (MAX_COUNTER_WIDTH + 14) / 8 bytes, so the
// input takes one counter per cycle while each yields at most one byte and nothing stalls.
// The next counter is packed in the cycle the emitter's last byte leaves.
// Reset clears the pending bits and empties both stages; no clearing pass is needed.
// An output stall holds the emitter; the input stalls while full and the emitter is busy.
module counter_bit_packer
    import cbp_pkg::*;
#(
    parameter int MAX_COUNTER_WIDTH = DEFAULT_MAX_COUNTER_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [IN_W-1:0]          count_word,
    input  logic                     last_counter,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [BITS_PER_BYTE-1:0] out_byte,
    output logic                     last_byte
);

    localparam int WORD_W = MAX_COUNTER_WIDTH + PARTIAL_W;
    localparam int BYTES  = (WORD_W + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
    localparam int NB_W   = $clog2(BYTES + 1);

    logic [CFG_W-1:0]  counter_width;
    logic              emit_free;
    logic              load;
    logic [WORD_W-1:0] load_word;
    logic [NB_W-1:0]   load_count;
    logic              load_last;
    logic [NB_W-1:0]   pending;
    pack_status_t      status;

    cbp_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .counter_width (counter_width)
    );

    cbp_pack #(
        .MAX_COUNTER_WIDTH (MAX_COUNTER_WIDTH)
    ) u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .counter_width (counter_width),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .count_word    (count_word),
        .last_counter  (last_counter),
        .emit_free     (emit_free),
        .load          (load),
        .load_word     (load_word),
        .load_count    (load_count),
        .load_last     (load_last),
        .status        (status)
    );

    cbp_emit #(
        .MAX_COUNTER_WIDTH (MAX_COUNTER_WIDTH)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_word  (load_word),
        .load_count (load_count),
        .load_last  (load_last),
        .emit_free  (emit_free),
        .pending    (pending),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> status.in_full)
        else $error("input stalled with an empty input register");

    a_last_clears_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_last) |=> (status.partial_count == '0))
        else $error("pending bits survived the final counter");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pending) <= BYTES)
        else $error("emitter holds more bytes than its word");

    a_busy_holds_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !load)
        else $error("emitter reloaded while a byte was stalled");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cbp_pkg::*;

    localparam int MAX_W       = DEFAULT_MAX_COUNTER_WIDTH;
    localparam int RANDOM_ITEMS = 175;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [IN_W-1:0] value;
        logic            last;
    } counter_item_t;

    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] data;
        logic                     last;
    } packed_byte_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0]    pwdata = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [IN_W-1:0]          count_word = '0;
    logic                     last_counter = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [BITS_PER_BYTE-1:0] out_byte;
    logic                     last_byte;

    counter_item_t     counter_q[$];
    packed_byte_t      expected_bytes[$];
    logic [CFG_W-1:0]  width_shadow = COUNTER_WIDTH_RESET;
    logic [PARTIAL_W-1:0] pend_bits = '0;
    logic [PCOUNT_W-1:0]  pend_count = '0;
    logic [63:0]       widths_seen = '0;
    logic              in_taken = 1'b0;
    logic              calm = 1'b0;
    int                gap_left = 0;
    int                stall_left = 0;
    int                counters_queued = 0;
    int                counters_sent = 0;
    int                bytes_checked = 0;
    int                errors = 0;
    int                cycle_count = 0;

    counter_bit_packer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .count_word    (count_word),
        .last_counter  (last_counter),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last_byte     (last_byte)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report(input string what);
        $display("[%0d] %s", cycle_count, what);
        errors++;
    endtask

    task automatic pack_counter(input logic [IN_W-1:0] value, input logic is_last);
        int eff;
        int cnt;
        int n;
        logic [BITS_PER_BYTE-1:0] acc;
        packed_byte_t b;
        eff = int'(width_shadow);
        if (eff == 0)
            eff = 1;
        if (eff > MAX_W)
            eff = MAX_W;
        acc = {1'b0, pend_bits};
        cnt = int'(pend_count);
        n = 0;
        for (int j = 0; j < eff; j++)
        begin
            acc[cnt] = value[j];
            cnt++;
            if (cnt == BITS_PER_BYTE)
            begin
                b.data = acc;
                b.last = 1'b0;
                expected_bytes.push_back(b);
                n++;
                acc = '0;
                cnt = 0;
            end
        end
        if (is_last)
        begin
            if (cnt > 0)
            begin
                b.data = acc;
                b.last = 1'b1;
                expected_bytes.push_back(b);
            end
            else if (n > 0)
            begin
                b = expected_bytes.pop_back();
                b.last = 1'b1;
                expected_bytes.push_back(b);
            end
            acc = '0;
            cnt = 0;
        end
        pend_bits = acc[PARTIAL_W-1:0];
        pend_count = cnt[PCOUNT_W-1:0];
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin : monitor
        packed_byte_t b;
        if (rst_n)
        begin
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                pack_counter(count_word, last_counter);
                counters_sent++;
            end
            if (out_valid && !out_stall)
            begin
                bytes_checked++;
                if (expected_bytes.size() == 0)
                    report($sformatf("unexpected byte %02h last %0b", out_byte, last_byte));
                else
                begin
                    b = expected_bytes.pop_front();
                    if (out_byte !== b.data)
                        report($sformatf("out_byte %02h, expected %02h", out_byte, b.data));
                    if (last_byte !== b.last)
                        report($sformatf("last_byte %0b, expected %0b", last_byte, b.last));
                end
            end
        end
    end

    always @(negedge clk)
    begin : driver
        logic v;
        counter_item_t it;
        v = in_valid;
        if (in_valid && in_taken)
            v = 1'b0;
        if (rst_n && !v)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (counter_q.size() > 0)
            begin
                it = counter_q.pop_front();
                count_word <= it.value;
                last_counter <= it.last;
                v = 1'b1;
                gap_left = pick_gap();
            end
        end
        in_valid <= v;
    end

    always @(negedge clk)
    begin : stall_gen
        int r;
        logic s;
        s = 1'b0;
        if (stall_left > 0)
        begin
            s = 1'b1;
            stall_left--;
        end
        else if (!calm)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                stall_left = $urandom_range(15, 40);
            else if (r < 25)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                s = 1'b1;
                stall_left--;
            end
        end
        out_stall <= s;
    end

    task automatic set_width(input logic [CFG_W-1:0] w);
        logic [APB_DATA_W-1:0] rd;
        logic [APB_DATA_W-1:0] junk;
        junk = $urandom();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_COUNTER_WIDTH;
        pwdata <= {junk[APB_DATA_W-1:CFG_W], w};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        width_shadow = w;
        widths_seen[w] = 1'b1;
        if (rd[CFG_W-1:0] !== w)
            report($sformatf("counter_width reads %0d, written %0d", rd[CFG_W-1:0], w));
    endtask

    task automatic add_counter(input logic [IN_W-1:0] value, input logic is_last);
        counter_item_t it;
        it.value = value;
        it.last = is_last;
        counter_q.push_back(it);
        counters_queued++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (counters_sent != counters_queued || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic [IN_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '1;
        if (r < 16)
            return '0;
        if (r < 26)
            return 32'd1 << $urandom_range(0, 31);
        return $urandom();
    endfunction

    function automatic logic [CFG_W-1:0] random_width();
        int r;
        logic [CFG_W-1:0] picks[13] = '{0, 1, 2, 7, 8, 9, 15, 16, 17, 31, 32, 33, 63};
        r = $urandom_range(0, 99);
        if (r < 50)
            return picks[$urandom_range(0, 12)];
        return CFG_W'($urandom_range(0, 63));
    endfunction

    task automatic random_phase(input int n_items);
        int left;
        int len;
        left = n_items;
        while (left > 0)
        begin
            len = $urandom_range(1, 12);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
            begin
                if (k == len - 1)
                    add_counter(random_value(), ($urandom_range(0, 5) != 0));
                else
                    add_counter(random_value(), ($urandom_range(0, 19) == 0));
            end
            left -= len;
        end
    endtask

    initial
    begin
        int n_random;
        int len;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_width(6'd32);
        @(posedge clk);
        add_counter(32'hFFFF_FFFF, 1'b0);
        add_counter(32'h0000_0000, 1'b0);
        add_counter(32'h8000_0000, 1'b0);
        add_counter(32'h0000_0001, 1'b1);
        wait_drained();

        set_width(6'd0);
        @(posedge clk);
        add_counter(32'hFFFF_FFFF, 1'b0);
        add_counter(32'hFFFF_FFFE, 1'b0);
        add_counter(32'h0000_0001, 1'b1);
        wait_drained();

        set_width(6'd63);
        @(posedge clk);
        add_counter(32'hFFFF_FFFF, 1'b1);
        add_counter(32'hA5A5_5A5A, 1'b1);
        wait_drained();

        set_width(6'd8);
        @(posedge clk);
        add_counter(32'hFFFF_FFAA, 1'b0);
        add_counter(32'h0000_0055, 1'b1);
        add_counter(32'h0000_00FF, 1'b1);
        wait_drained();

        set_width(6'd3);
        @(posedge clk);
        add_counter(32'hFFFF_FFFD, 1'b0);
        add_counter(32'h0000_0002, 1'b0);
        add_counter(32'h0000_0007, 1'b0);
        add_counter(32'h0000_0005, 1'b1);
        add_counter(32'h0000_0006, 1'b1);
        wait_drained();

        set_width(6'd1);
        @(posedge clk);
        add_counter(32'h0000_0001, 1'b1);
        add_counter(32'h0000_0000, 1'b1);
        wait_drained();

        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            set_width(random_width());
            calm = ($urandom_range(0, 3) == 0);
            @(posedge clk);
            len = $urandom_range(8, 24);
            random_phase(len);
            n_random += len;
            wait_drained();
        end

        calm = 1'b0;
        set_width(COUNTER_WIDTH_RESET);
        @(posedge clk);
        random_phase(6);
        add_counter(random_value(), 1'b1);
        wait_drained();

        $display("Sent %0d counters, checked %0d packed bytes.", counters_sent, bytes_checked);
        $display("Exercised %0d distinct counter_width settings.", $countones(widths_seen));
        if (errors == 0)
            $display("counter_bit_packer: match");
        else
            $display("counter_bit_packer: mismatch");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped at the cycle limit.");
        $display("counter_bit_packer: mismatch");
        $finish;
    end

endmodule
